/* rtl/rkbs_pkg.sv */
package rkbs_pkg;

  localparam int KEY_W = 27;
  localparam int TAG_W = 8;
  localparam int MAX_RECORDS_DEF = 64;

  // One stored record: key in the upper bits, tag below.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

endpackage

/* rtl/rkbs_mem.sv */
module rkbs_mem #(
  parameter int MAX_RECORDS = rkbs_pkg::MAX_RECORDS_DEF,
  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  rkbs_pkg::rec_t  wdata,
  input  logic [AW-1:0]   raddr,
  output rkbs_pkg::rec_t  rdata
);
  import rkbs_pkg::*;

  rec_t mem [MAX_RECORDS];
  rec_t rdata_r;

  // Single write port, single registered read port; read returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rkbs_ctrl.sv */
module rkbs_ctrl #(
  parameter int MAX_RECORDS = rkbs_pkg::MAX_RECORDS_DEF,
  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
  localparam int CW = $clog2(MAX_RECORDS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rkbs_pkg::KEY_W-1:0]  in_key,
  input  logic [rkbs_pkg::TAG_W-1:0]  in_tag,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rkbs_pkg::KEY_W-1:0]  out_sorted_key,
  output logic [rkbs_pkg::TAG_W-1:0]  out_sorted_tag,
  output logic                        out_final_res,
  output logic                        out_overflow,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output rkbs_pkg::rec_t              mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  rkbs_pkg::rec_t              mem_rdata
);
  import rkbs_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_FIRST, S_RUN, S_TAIL, S_ORD, S_OWAIT, S_OHOLD
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             dropped_r, dropped_nxt;
  logic [AW-1:0]    end_r, end_nxt;
  logic [AW-1:0]    last_idx_r, last_idx_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    out_idx_r, out_idx_nxt;
  rec_t             carry_r, carry_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic             out_final_r, out_final_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             store;
  logic [CW-1:0]    n_cnt;
  logic [AW:0]      pos_p1;
  logic [AW:0]      pos_p2;
  logic             swap;

  assign store  = cnt_r < CW'(MAX_RECORDS);
  assign n_cnt  = cnt_r + CW'(store);
  assign pos_p1 = {1'b0, pos_r} + (AW+1)'(1);
  assign pos_p2 = {1'b0, pos_r} + (AW+1)'(2);
  assign swap   = carry_r.key > mem_rdata.key;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dropped_nxt   = dropped_r;
    end_nxt       = end_r;
    last_idx_nxt  = last_idx_r;
    pos_nxt       = pos_r;
    out_idx_nxt   = out_idx_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_tag_nxt   = out_tag_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[AW-1:0];
    mem_wdata     = '{key: in_key, tag: in_tag};
    mem_raddr     = '0;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          mem_we      = store;
          cnt_nxt     = n_cnt;
          dropped_nxt = dropped_r | ~store;
          if (in_last) begin
            last_idx_nxt = AW'(n_cnt - CW'(1));
            end_nxt      = AW'(n_cnt - CW'(1));
            // a single record needs no sort; read it after this write lands
            state_nxt    = (n_cnt < CW'(2)) ? S_ORD : S_FIRST;
          end
        end
      end
      S_FIRST: begin
        carry_nxt = mem_rdata;
        pos_nxt   = '0;
        mem_raddr = AW'(1);
        state_nxt = S_RUN;
      end
      S_RUN: begin
        // write the smaller back, carry the larger forward
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = swap ? mem_rdata : carry_r;
        carry_nxt = swap ? carry_r : mem_rdata;
        pos_nxt   = pos_p1[AW-1:0];
        if (pos_p1 == {1'b0, end_r}) begin
          state_nxt = S_TAIL;
        end else begin
          mem_raddr = pos_p2[AW-1:0];
        end
      end
      S_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = end_r;
        mem_wdata = carry_r;
        if (end_r == AW'(1)) begin
          out_idx_nxt = '0;
          state_nxt   = S_OWAIT;
        end else begin
          end_nxt   = end_r - AW'(1);
          state_nxt = S_FIRST;
        end
      end
      S_ORD: begin
        out_idx_nxt = '0;
        state_nxt   = S_OWAIT;
      end
      S_OWAIT: begin
        out_key_nxt   = mem_rdata.key;
        out_tag_nxt   = mem_rdata.tag;
        out_final_nxt = out_idx_r == last_idx_r;
        out_ovf_nxt   = dropped_r;
        out_valid_nxt = 1'b1;
        out_idx_nxt   = out_idx_r + AW'(1);
        state_nxt     = S_OHOLD;
      end
      S_OHOLD: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_final_r) begin
            cnt_nxt     = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_LOAD;
          end else begin
            mem_raddr = out_idx_r;
            state_nxt = S_OWAIT;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    end_r       <= end_nxt;
    last_idx_r  <= last_idx_nxt;
    pos_r       <= pos_nxt;
    out_idx_r   <= out_idx_nxt;
    carry_r     <= carry_nxt;
    out_key_r   <= out_key_nxt;
    out_tag_r   <= out_tag_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall       = state_r != S_LOAD;
  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_sorted_tag = out_tag_r;
  assign out_final_res  = out_final_r;
  assign out_overflow   = out_ovf_r;

endmodule

/* rtl/record_key_bubble_sorter_top.sv */
// Record key bubble sorter. Load a set of records (27-bit key, 8-bit tag),
// one word per cycle while in_stall is low, and mark the final word with
// in_last; the set is then sorted in ascending key order, equal keys
// keeping their load order, and sent out one word per record with
// out_final_res on the last one. Words that arrive once MAX_RECORDS are
// held are dropped, and every output word of that set shows out_overflow.
// For a set of n stored records the sort runs n-1 passes over the single
// record memory; a pass over positions 0..e reads and writes that memory
// once per compare, between a first read and a closing write of the
// carried record. Each output word goes through the registered memory
// read, then the output register, and the next word is read only once
// the receiver has taken the current one. in_stall is high from the
// closing word until the final output word is taken; no new set is taken
// in meanwhile. Nothing needs clearing after reset: only entries written
// in the current set are read.
module record_key_bubble_sorter_top #(
  parameter int MAX_RECORDS = rkbs_pkg::MAX_RECORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rkbs_pkg::KEY_W-1:0]  in_key,
  input  logic [rkbs_pkg::TAG_W-1:0]  in_tag,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rkbs_pkg::KEY_W-1:0]  out_sorted_key,
  output logic [rkbs_pkg::TAG_W-1:0]  out_sorted_tag,
  output logic                        out_final_res,
  output logic                        out_overflow
);
  import rkbs_pkg::*;

  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  // memory access lines between the sequencer and the record store
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  rec_t          mem_wdata;
  rec_t          mem_rdata;

  // Sequencer: load, bubble passes with the larger record carried in a
  // register, and readout through the output register.
  rkbs_ctrl #(.MAX_RECORDS(MAX_RECORDS)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key         (in_key),
    .in_tag         (in_tag),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sorted_key (out_sorted_key),
    .out_sorted_tag (out_sorted_tag),
    .out_final_res  (out_final_res),
    .out_overflow   (out_overflow),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  // Record store: one write and one registered read per cycle.
  rkbs_mem #(.MAX_RECORDS(MAX_RECORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* rtl/rkbs_check.sv */
module rkbs_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [rkbs_pkg::KEY_W-1:0]  out_sorted_key,
  input logic [rkbs_pkg::TAG_W-1:0]  out_sorted_tag,
  input logic                        out_final_res,
  input logic                        out_overflow
);
  import rkbs_pkg::*;

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_key) &&
      $stable(out_sorted_tag) && $stable(out_final_res) && $stable(out_overflow))
    else $error("stalled output word changed");

  // no input is taken while a set is being emitted
  a_no_load_in_output: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall))
    else $error("input open while output word pending");

  // a word without last produces no output
  a_no_out_midset: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last |=> !out_valid && !in_stall)
    else $error("output or stall after a mid-set word");

  // after the final word is taken the block returns to loading
  a_final_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_final_res |=> !out_valid && !in_stall)
    else $error("set did not close after final word");

endmodule

bind record_key_bubble_sorter_top rkbs_check u_rkbs_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last        (in_last),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sorted_key (out_sorted_key),
  .out_sorted_tag (out_sorted_tag),
  .out_final_res  (out_final_res),
  .out_overflow   (out_overflow)
);

/* verif/record_key_sort_checker.sv */
module record_key_sort_checker #(
  parameter int MAX_RECORDS = rkbs_pkg::MAX_RECORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [rkbs_pkg::KEY_W-1:0]  in_key,
  input  logic [rkbs_pkg::TAG_W-1:0]  in_tag,
  input  logic                        in_last,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [rkbs_pkg::KEY_W-1:0]  out_sorted_key,
  input  logic [rkbs_pkg::TAG_W-1:0]  out_sorted_tag,
  input  logic                        out_final_res,
  input  logic                        out_overflow,
  output int                          fail_count,
  output int                          pending_words
);

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [rkbs_pkg::KEY_W-1:0] key;
    logic [rkbs_pkg::TAG_W-1:0] tag;
    logic                       final_res;
    logic                       overflow;
  } sorted_word_t;

  rkbs_pkg::rec_t held_recs [MAX_RECORDS];
  int             held_cnt;
  bit             dropped;
  sorted_word_t   sorted_q [$];
  int             errors;

  // Stable bubble sort of the held set; swap only on strictly greater keys.
  task automatic sort_held_set();
    rkbs_pkg::rec_t tmp;
    sorted_word_t   w;
    for (int pass = 0; pass < held_cnt - 1; pass++) begin
      for (int pos = 0; pos + 1 < held_cnt - pass; pos++) begin
        if (held_recs[pos].key > held_recs[pos+1].key) begin
          tmp              = held_recs[pos];
          held_recs[pos]   = held_recs[pos+1];
          held_recs[pos+1] = tmp;
        end
      end
    end
    for (int i = 0; i < held_cnt; i++) begin
      w.key       = held_recs[i].key;
      w.tag       = held_recs[i].tag;
      w.final_res = (i == held_cnt - 1);
      w.overflow  = dropped;
      sorted_q.push_back(w);
    end
    held_cnt = 0;
    dropped  = 1'b0;
  endtask

  always @(posedge clk) begin
    sorted_word_t got;
    sorted_word_t exp_w;
    if (!rst_n) begin
      held_cnt = 0;
      dropped  = 1'b0;
      sorted_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_sorted_key, out_sorted_tag, out_final_res, out_overflow};
        if (sorted_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected word key=%h tag=%h final=%b ovf=%b", $time,
                     got.key, got.tag, got.final_res, got.overflow);
        end else begin
          exp_w = sorted_q.pop_front();
          if (got !== exp_w) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: mismatch expected key=%h tag=%h final=%b ovf=%b, got key=%h tag=%h final=%b ovf=%b",
                       $time, exp_w.key, exp_w.tag, exp_w.final_res, exp_w.overflow,
                       got.key, got.tag, got.final_res, got.overflow);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (held_cnt < MAX_RECORDS) begin
          held_recs[held_cnt] = '{in_key, in_tag};
          held_cnt++;
        end else begin
          dropped = 1'b1;
        end
        if (in_last)
          sort_held_set();
      end
    end
    fail_count    <= errors;
    pending_words <= sorted_q.size();
  end

endmodule

/* verif/tb.sv */
module tb;

  localparam int MAX_RECORDS  = rkbs_pkg::MAX_RECORDS_DEF;
  localparam int RANDOM_WORDS = 500;
  // Far above the slowest legal run: a few full sets sorting, every output
  // word waiting out the longest receiver stall, every input the longest gap.
  localparam int unsigned RUN_LIMIT = 2_000_000;

  localparam logic [rkbs_pkg::KEY_W-1:0] KEY_ALL_ONES = '1;
  localparam logic [rkbs_pkg::KEY_W-1:0] KEY_TOP_IN_RANGE = 27'd99999999;

  // How keys of one set are drawn.
  typedef enum int {
    KEY_FULL,      // any 27-bit value, above the stated range too
    KEY_IN_RANGE,  // eight-digit identifiers
    KEY_DUP,       // tiny range, many equal keys to expose instability
    KEY_EXTREME    // only zero and all ones
  } key_style_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [rkbs_pkg::KEY_W-1:0] in_key = '0;
  logic [rkbs_pkg::TAG_W-1:0] in_tag = '0;
  logic                       in_last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [rkbs_pkg::KEY_W-1:0] out_sorted_key;
  logic [rkbs_pkg::TAG_W-1:0] out_sorted_tag;
  logic                       out_final_res;
  logic                       out_overflow;

  int          fail_count;
  int          pending_words;
  int unsigned cycle_cnt = 0;
  int          stall_run = 0;
  bit          no_gaps = 1'b0;
  int          words_sent = 0;

  record_key_bubble_sorter_top #(.MAX_RECORDS(MAX_RECORDS)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key         (in_key),
    .in_tag         (in_tag),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sorted_key (out_sorted_key),
    .out_sorted_tag (out_sorted_tag),
    .out_final_res  (out_final_res),
    .out_overflow   (out_overflow)
  );

  record_key_sort_checker #(.MAX_RECORDS(MAX_RECORDS)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key         (in_key),
    .in_tag         (in_tag),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sorted_key (out_sorted_key),
    .out_sorted_tag (out_sorted_tag),
    .out_final_res  (out_final_res),
    .out_overflow   (out_overflow),
    .fail_count     (fail_count),
    .pending_words  (pending_words)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("** record_key_bubble_sorter_top: FAILED **");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long.
  function automatic int random_gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75)
      return $urandom_range(1, 3);
    else if (r < 95)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver back-pressure: alternate stall bursts and free-running
  // stretches, with an occasional long stretch of no stall at all.
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 99) < 35) begin
      out_stall <= 1'b1;
      stall_run <= random_gap_len() - 1;
    end else begin
      out_stall <= 1'b0;
      stall_run <= ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(0, 12);
    end
  end

  function automatic logic [rkbs_pkg::KEY_W-1:0] pick_key(key_style_t style);
    logic [31:0] r;
    r = $urandom();
    case (style)
      KEY_FULL:     return r[rkbs_pkg::KEY_W-1:0];
      KEY_IN_RANGE: return rkbs_pkg::KEY_W'($urandom_range(0, 99999999));
      KEY_DUP:      return rkbs_pkg::KEY_W'($urandom_range(0, 7));
      default:      return r[0] ? KEY_ALL_ONES : '0;
    endcase
  endfunction

  // Present one word and hold it until the block takes it.
  task automatic send_record(input logic [rkbs_pkg::KEY_W-1:0] key,
                             input logic [rkbs_pkg::TAG_W-1:0] tag,
                             input logic last);
    int gap;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 99) < 30)
      gap = random_gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key   <= key;
    in_tag   <= tag;
    in_last  <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Send a complete set of n records; the final one closes it.
  task automatic send_set(input int n, input key_style_t style);
    for (int i = 0; i < n; i++) begin
      send_record(pick_key(style), rkbs_pkg::TAG_W'($urandom_range(0, 255)), i == n - 1);
      words_sent++;
    end
  endtask

  // Drop valid and hold off until every sorted word has been taken.
  task automatic wait_sorted_out();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  initial begin
    int         set_idx;
    int         set_len;
    int         r;
    key_style_t style;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-record sets at both key extremes and both tag extremes.
    send_record('0, 8'h00, 1'b1);
    send_record(KEY_ALL_ONES, 8'hFF, 1'b1);
    // Two records in reverse order: one swap.
    send_record(KEY_TOP_IN_RANGE, 8'd1, 1'b0);
    send_record('0, 8'd2, 1'b1);
    // Equal keys around a smaller one: load order must survive the sort.
    send_record(27'd42, 8'd10, 1'b0);
    send_record(27'd42, 8'd11, 1'b0);
    send_record(27'd7,  8'd12, 1'b0);
    send_record(27'd42, 8'd13, 1'b0);
    send_record(27'd42, 8'd14, 1'b1);
    // Nearly descending, with keys above the eight-digit range.
    send_record(KEY_ALL_ONES,        8'd20, 1'b0);
    send_record(27'h4000000,         8'd21, 1'b0);
    send_record(27'd100000000,       8'd22, 1'b0);
    send_record(KEY_TOP_IN_RANGE,    8'd23, 1'b0);
    send_record(27'd1,               8'd24, 1'b0);
    send_record('0,                  8'd25, 1'b1);
    // Already sorted: no swaps at all.
    send_record(27'd3,  8'd30, 1'b0);
    send_record(27'd5,  8'd31, 1'b0);
    send_record(27'd5,  8'd32, 1'b0);
    send_record(27'd9,  8'd33, 1'b1);
    // Alternating bit patterns in key and tag.
    send_record(27'h5555555, 8'hAA, 1'b0);
    send_record(27'h2AAAAAA, 8'h55, 1'b1);
    wait_sorted_out();

    // Random sets, mostly small; full and overflowing sets forced early on.
    set_idx = 0;
    while (words_sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (set_idx == 2)
        set_len = MAX_RECORDS;              // exactly full
      else if (set_idx == 5)
        set_len = MAX_RECORDS + 1;          // closing word itself dropped
      else if (set_idx == 9)
        set_len = MAX_RECORDS + 6;          // several dropped
      else if (r < 75)
        set_len = $urandom_range(1, 8);
      else if (r < 92)
        set_len = $urandom_range(9, 24);
      else if (r < 97)
        set_len = $urandom_range(25, MAX_RECORDS - 1);
      else
        set_len = $urandom_range(MAX_RECORDS, MAX_RECORDS + 8);
      style   = key_style_t'($urandom_range(0, 3));
      no_gaps = ($urandom_range(0, 4) == 0);
      send_set(set_len, style);
      set_idx++;
      if (set_idx % 8 == 0)
        wait_sorted_out();
    end
    no_gaps = 1'b0;

    wait_sorted_out();
    // Let any stray word show up before the verdict.
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("** record_key_bubble_sorter_top: PASSED **");
    else
      $display("** record_key_bubble_sorter_top: FAILED **");
    $finish;
  end

endmodule
